// ----- rtl/bt2d_pkg.sv -----
`timescale 1ns / 1ps
package bt2d_pkg;

    localparam int RangeWidth = 16;
    localparam int PosWidth   = 20;
    localparam int RegCount   = 6;
    localparam int IdxWidth   = 3;

    typedef enum logic [IdxWidth-1:0] {
        REG_ONE_X   = 3'd0,
        REG_ONE_Y   = 3'd1,
        REG_TWO_X   = 3'd2,
        REG_TWO_Y   = 3'd3,
        REG_THREE_X = 3'd4,
        REG_THREE_Y = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [RangeWidth-1:0] range_one;
        logic [RangeWidth-1:0] range_two;
        logic [RangeWidth-1:0] range_three;
    } in_beat_t;

    typedef struct packed {
        logic signed [PosWidth-1:0] pos_x;
        logic signed [PosWidth-1:0] pos_y;
        logic                       degenerate;
        logic                       clipped;
    } out_beat_t;

    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic degenerate;
    } solve_ctl_t;

endpackage

// ----- rtl/bt2d_div_cell.sv -----
`timescale 1ns / 1ps
module bt2d_div_cell #(
    parameter int NUM_WIDTH = 80,
    parameter int DEN_WIDTH = 36,
    parameter int STEP      = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 valid_in,
    input  logic [NUM_WIDTH-1:0] num_x_in,
    input  logic [NUM_WIDTH-1:0] num_y_in,
    input  logic [DEN_WIDTH:0]   rem_x_in,
    input  logic [DEN_WIDTH:0]   rem_y_in,
    input  logic [NUM_WIDTH-1:0] quo_x_in,
    input  logic [NUM_WIDTH-1:0] quo_y_in,
    input  logic [DEN_WIDTH-1:0] den_in,
    input  bt2d_pkg::solve_ctl_t ctl_in,
    output logic                 valid_out,
    output logic [NUM_WIDTH-1:0] num_x_out,
    output logic [NUM_WIDTH-1:0] num_y_out,
    output logic [DEN_WIDTH:0]   rem_x_out,
    output logic [DEN_WIDTH:0]   rem_y_out,
    output logic [NUM_WIDTH-1:0] quo_x_out,
    output logic [NUM_WIDTH-1:0] quo_y_out,
    output logic [DEN_WIDTH-1:0] den_out,
    output bt2d_pkg::solve_ctl_t ctl_out
);
    import bt2d_pkg::*;

    localparam int Bit = NUM_WIDTH - 1 - STEP;

    logic [DEN_WIDTH:0] tx;
    logic [DEN_WIDTH:0] ty;
    logic               gx;
    logic               gy;
    logic               valid_reg;
    logic [DEN_WIDTH:0] rem_x_reg;
    logic [DEN_WIDTH:0] rem_y_reg;
    logic [NUM_WIDTH-1:0] quo_x_reg;
    logic [NUM_WIDTH-1:0] quo_y_reg;
    logic [NUM_WIDTH-1:0] num_x_reg;
    logic [NUM_WIDTH-1:0] num_y_reg;
    logic [DEN_WIDTH-1:0] den_reg;
    solve_ctl_t           ctl_reg;

    always_comb
    begin
        tx = {rem_x_in[DEN_WIDTH-1:0], num_x_in[Bit]};
        ty = {rem_y_in[DEN_WIDTH-1:0], num_y_in[Bit]};
        gx = (tx >= {1'b0, den_in});
        gy = (ty >= {1'b0, den_in});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_x_reg <= gx ? (tx - {1'b0, den_in}) : tx;
            rem_y_reg <= gy ? (ty - {1'b0, den_in}) : ty;
            quo_x_reg <= {quo_x_in[NUM_WIDTH-2:0], gx};
            quo_y_reg <= {quo_y_in[NUM_WIDTH-2:0], gy};
            num_x_reg <= num_x_in;
            num_y_reg <= num_y_in;
            den_reg   <= den_in;
            ctl_reg   <= ctl_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_x_out = rem_x_reg;
    assign rem_y_out = rem_y_reg;
    assign quo_x_out = quo_x_reg;
    assign quo_y_out = quo_y_reg;
    assign num_x_out = num_x_reg;
    assign num_y_out = num_y_reg;
    assign den_out   = den_reg;
    assign ctl_out   = ctl_reg;

endmodule

// ----- rtl/bt2d_front.sv -----
`timescale 1ns / 1ps
module bt2d_front #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 4,
    parameter int NUM_WIDTH   = 80,
    parameter int DEN_WIDTH   = 36
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          valid_in,
    input  bt2d_pkg::in_beat_t            beat_in,
    input  logic signed [COORD_WIDTH-1:0] x1,
    input  logic signed [COORD_WIDTH-1:0] y1,
    input  logic signed [COORD_WIDTH-1:0] x2,
    input  logic signed [COORD_WIDTH-1:0] y2,
    input  logic signed [COORD_WIDTH-1:0] x3,
    input  logic signed [COORD_WIDTH-1:0] y3,
    output logic                          valid_out,
    output logic [NUM_WIDTH-1:0]          num_x,
    output logic [NUM_WIDTH-1:0]          num_y,
    output logic [DEN_WIDTH-1:0]          den,
    output bt2d_pkg::solve_ctl_t          ctl
);
    import bt2d_pkg::*;

    localparam int MW = (COORD_WIDTH > RangeWidth) ? COORD_WIDTH : RangeWidth;
    localparam int DW = COORD_WIDTH + 2;
    localparam int SW = 2 * MW + 3;
    localparam int PW = DW + SW + 1;
    localparam int QW = 2 * DW + 1;

    logic signed [DW-1:0] a_c;
    logic signed [DW-1:0] b_c;
    logic signed [DW-1:0] d_c;
    logic signed [DW-1:0] e_c;
    logic signed [SW-1:0] sq_c;
    logic signed [SW-1:0] sq_f;

    logic                 v1_reg;
    logic signed [DW-1:0] a_reg;
    logic signed [DW-1:0] b_reg;
    logic signed [DW-1:0] d_reg;
    logic signed [DW-1:0] e_reg;
    logic signed [SW-1:0] c_reg;
    logic signed [SW-1:0] f_reg;

    logic                 v2_reg;
    logic signed [PW-1:0] ce_reg;
    logic signed [PW-1:0] fb_reg;
    logic signed [PW-1:0] af_reg;
    logic signed [PW-1:0] cd_reg;
    logic signed [QW-1:0] ae_reg;
    logic signed [QW-1:0] bd_reg;

    logic                 v3_reg;
    logic [NUM_WIDTH-1:0] nx_reg;
    logic [NUM_WIDTH-1:0] ny_reg;
    logic [DEN_WIDTH-1:0] den_reg;
    solve_ctl_t           ctl_reg;

    logic signed [PW:0]   nx_s;
    logic signed [PW:0]   ny_s;
    logic signed [QW:0]   det_s;
    logic [PW:0]          nx_m;
    logic [PW:0]          ny_m;
    logic [QW:0]          det_m;

    always_comb
    begin
        a_c = DW'(2 * (DW'(x2) - DW'(x1)));
        b_c = DW'(2 * (DW'(y2) - DW'(y1)));
        d_c = DW'(2 * (DW'(x3) - DW'(x2)));
        e_c = DW'(2 * (DW'(y3) - DW'(y2)));
        sq_c = SW'($signed({1'b0, beat_in.range_one}) * $signed({1'b0, beat_in.range_one}))
             - SW'($signed({1'b0, beat_in.range_two}) * $signed({1'b0, beat_in.range_two}))
             - SW'(x1 * x1) + SW'(x2 * x2) - SW'(y1 * y1) + SW'(y2 * y2);
        sq_f = SW'($signed({1'b0, beat_in.range_two}) * $signed({1'b0, beat_in.range_two}))
             - SW'($signed({1'b0, beat_in.range_three}) * $signed({1'b0, beat_in.range_three}))
             - SW'(x2 * x2) + SW'(x3 * x3) - SW'(y2 * y2) + SW'(y3 * y3);
        nx_s  = (PW+1)'(ce_reg) - (PW+1)'(fb_reg);
        ny_s  = (PW+1)'(af_reg) - (PW+1)'(cd_reg);
        det_s = (QW+1)'(ae_reg) - (QW+1)'(bd_reg);
        nx_m  = nx_s[PW] ? (PW+1)'(-nx_s) : nx_s;
        ny_m  = ny_s[PW] ? (PW+1)'(-ny_s) : ny_s;
        det_m = det_s[QW] ? (QW+1)'(-det_s) : det_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg  <= a_c;
            b_reg  <= b_c;
            d_reg  <= d_c;
            e_reg  <= e_c;
            c_reg  <= sq_c;
            f_reg  <= sq_f;
            ce_reg <= PW'(c_reg * e_reg);
            fb_reg <= PW'(f_reg * b_reg);
            af_reg <= PW'(a_reg * f_reg);
            cd_reg <= PW'(c_reg * d_reg);
            ae_reg <= QW'(a_reg * e_reg);
            bd_reg <= QW'(b_reg * d_reg);
            nx_reg <= NUM_WIDTH'(nx_m) << FRAC_BITS;
            ny_reg <= NUM_WIDTH'(ny_m) << FRAC_BITS;
            den_reg <= DEN_WIDTH'(det_m);
            ctl_reg.x_neg      <= nx_s[PW] ^ det_s[QW];
            ctl_reg.y_neg      <= ny_s[PW] ^ det_s[QW];
            ctl_reg.degenerate <= (det_s == '0);
        end
    end

    assign valid_out = v3_reg;
    assign num_x     = nx_reg;
    assign num_y     = ny_reg;
    assign den       = den_reg;
    assign ctl       = ctl_reg;

endmodule

// ----- rtl/beacon_trilateration_2d_top.sv -----
`timescale 1ns / 1ps
// Three-anchor 2-D position solver. Write the six anchor coordinates through
// the cfg port, then stream range triples; one position comes out per beat, and
// one beat is accepted every cycle while the output is not stalled. Each beat
// passes three front stages that form the equations, products and determinant,
// a row of NUM_WIDTH restoring-divider cells that produce one quotient bit each
// per cycle for x and y at once, and one output register (NUM_WIDTH =
// COORD_WIDTH + 2*max(COORD_WIDTH, 16) + FRAC_BITS + 7).
// A stalled output freezes the whole pipeline. A zero determinant gives
// degenerate = 1 and zero coordinates; a quotient beyond 20 bits saturates and
// sets clipped.
module beacon_trilateration_2d_top #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [COORD_WIDTH-1:0]       cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  bt2d_pkg::in_beat_t           in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output bt2d_pkg::out_beat_t          out_data
);
    import bt2d_pkg::*;

    localparam int MW  = (COORD_WIDTH > RangeWidth) ? COORD_WIDTH : RangeWidth;
    localparam int DW  = COORD_WIDTH + 2;
    localparam int SW  = 2 * MW + 3;
    localparam int PW  = DW + SW + 1;
    localparam int QW  = 2 * DW + 1;
    localparam int NW  = PW + 1 + FRAC_BITS;
    localparam int DNW = QW + 1;
    localparam int Lim = 2 ** (PosWidth - 1);

    logic signed [COORD_WIDTH-1:0] anc_reg [RegCount];
    logic adv;

    logic              fv;
    logic [NW-1:0]     fnx;
    logic [NW-1:0]     fny;
    logic [DNW-1:0]    fden;
    solve_ctl_t        fctl;

    logic              cv   [NW+1];
    logic [NW-1:0]     cnx  [NW+1];
    logic [NW-1:0]     cny  [NW+1];
    logic [DNW:0]      crx  [NW+1];
    logic [DNW:0]      cry  [NW+1];
    logic [NW-1:0]     cqx  [NW+1];
    logic [NW-1:0]     cqy  [NW+1];
    logic [DNW-1:0]    cden [NW+1];
    solve_ctl_t        cctl [NW+1];

    logic              out_valid_reg;
    out_beat_t         out_reg;
    logic [PosWidth-1:0] px;
    logic [PosWidth-1:0] py;
    logic              clx;
    logic              cly;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RegCount; i++)
            begin
                anc_reg[i] <= '0;
            end
        end
        else if (cfg_we && (cfg_index < 3'(RegCount)))
        begin
            anc_reg[cfg_index] <= cfg_data;
        end
    end

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    bt2d_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .NUM_WIDTH   (NW),
        .DEN_WIDTH   (DNW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (in_valid),
        .beat_in   (in_data),
        .x1        (anc_reg[REG_ONE_X]),
        .y1        (anc_reg[REG_ONE_Y]),
        .x2        (anc_reg[REG_TWO_X]),
        .y2        (anc_reg[REG_TWO_Y]),
        .x3        (anc_reg[REG_THREE_X]),
        .y3        (anc_reg[REG_THREE_Y]),
        .valid_out (fv),
        .num_x     (fnx),
        .num_y     (fny),
        .den       (fden),
        .ctl       (fctl)
    );

    assign cv[0]   = fv;
    assign cnx[0]  = fnx;
    assign cny[0]  = fny;
    assign crx[0]  = '0;
    assign cry[0]  = '0;
    assign cqx[0]  = '0;
    assign cqy[0]  = '0;
    assign cden[0] = fden;
    assign cctl[0] = fctl;

    for (genvar g = 0; g < NW; g++)
    begin : g_cell
        bt2d_div_cell #(
            .NUM_WIDTH (NW),
            .DEN_WIDTH (DNW),
            .STEP      (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .valid_in  (cv[g]),
            .num_x_in  (cnx[g]),
            .num_y_in  (cny[g]),
            .rem_x_in  (crx[g]),
            .rem_y_in  (cry[g]),
            .quo_x_in  (cqx[g]),
            .quo_y_in  (cqy[g]),
            .den_in    (cden[g]),
            .ctl_in    (cctl[g]),
            .valid_out (cv[g+1]),
            .num_x_out (cnx[g+1]),
            .num_y_out (cny[g+1]),
            .rem_x_out (crx[g+1]),
            .rem_y_out (cry[g+1]),
            .quo_x_out (cqx[g+1]),
            .quo_y_out (cqy[g+1]),
            .den_out   (cden[g+1]),
            .ctl_out   (cctl[g+1])
        );
    end

    always_comb
    begin
        clx = cqx[NW] > NW'(Lim - (cctl[NW].x_neg ? 0 : 1));
        cly = cqy[NW] > NW'(Lim - (cctl[NW].y_neg ? 0 : 1));
        px  = clx ? PosWidth'(Lim - (cctl[NW].x_neg ? 0 : 1)) : cqx[NW][PosWidth-1:0];
        py  = cly ? PosWidth'(Lim - (cctl[NW].y_neg ? 0 : 1)) : cqy[NW][PosWidth-1:0];
        if (cctl[NW].x_neg)
        begin
            px = -px;
        end
        if (cctl[NW].y_neg)
        begin
            py = -py;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= cv[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (cctl[NW].degenerate)
            begin
                out_reg.pos_x      <= '0;
                out_reg.pos_y      <= '0;
                out_reg.degenerate <= 1'b1;
                out_reg.clipped    <= 1'b0;
            end
            else
            begin
                out_reg.pos_x      <= px;
                out_reg.pos_y      <= py;
                out_reg.degenerate <= 1'b0;
                out_reg.clipped    <= clx || cly;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- rtl/bt2d_checker.sv -----
`timescale 1ns / 1ps
module bt2d_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input bt2d_pkg::out_beat_t out_data
);
    import bt2d_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat dropped while stalled");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.degenerate |->
            out_data.pos_x == '0 && out_data.pos_y == '0 && !out_data.clipped)
        else $error("degenerate beat carries position");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while output stalled");

endmodule

bind beacon_trilateration_2d_top bt2d_checker u_bt2d_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import bt2d_pkg::*;

    localparam int          CoordWidth = 16;
    localparam int          DrainWait  = 120;
    localparam int          CycleLimit = 400000;
    localparam logic [2:0]  REG_SPARE_SIX   = 3'd6;
    localparam logic [2:0]  REG_SPARE_SEVEN = 3'd7;
    localparam logic signed [127:0] PosMax = 128'sd524287;
    localparam logic signed [127:0] PosMin = -128'sd524288;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [2:0]            cfg_index = '0;
    logic [CoordWidth-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_beat_t              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_beat_t             out_data;

    logic signed [CoordWidth-1:0] anchor_xy [RegCount];
    in_beat_t   range_q [$];
    out_beat_t  position_q [$];
    int         errors = 0;
    int         cycles = 0;
    int         send_gap = 0;
    int         recv_stall = 0;
    int         hold_left = 0;
    bit         quiet = 1'b0;
    bit         long_hold_req = 1'b0;
    bit         long_hold_done = 1'b0;

    beacon_trilateration_2d_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [PosWidth-1:0] solve_axis(logic signed [127:0] num,
                                                       logic signed [127:0] det,
                                                       inout logic clip);
        logic signed [127:0] q;
        q = (num <<< 4) / det;
        if (q > PosMax)
        begin
            clip = 1'b1;
            q = PosMax;
        end
        else if (q < PosMin)
        begin
            clip = 1'b1;
            q = PosMin;
        end
        return q[PosWidth-1:0];
    endfunction

    function automatic out_beat_t predict_position(in_beat_t b);
        logic signed [127:0] x1, y1, x2, y2, x3, y3, r1, r2, r3;
        logic signed [127:0] a, bb, c, d, e, f, det;
        logic                clip;
        out_beat_t           p;
        x1 = anchor_xy[REG_ONE_X];   y1 = anchor_xy[REG_ONE_Y];
        x2 = anchor_xy[REG_TWO_X];   y2 = anchor_xy[REG_TWO_Y];
        x3 = anchor_xy[REG_THREE_X]; y3 = anchor_xy[REG_THREE_Y];
        r1 = $signed({112'd0, b.range_one});
        r2 = $signed({112'd0, b.range_two});
        r3 = $signed({112'd0, b.range_three});
        a = 2 * (x2 - x1);
        bb = 2 * (y2 - y1);
        d = 2 * (x3 - x2);
        e = 2 * (y3 - y2);
        c = r1 * r1 - r2 * r2 - x1 * x1 + x2 * x2 - y1 * y1 + y2 * y2;
        f = r2 * r2 - r3 * r3 - x2 * x2 + x3 * x3 - y2 * y2 + y3 * y3;
        det = a * e - bb * d;
        p = '0;
        clip = 1'b0;
        if (det == 0)
            p.degenerate = 1'b1;
        else
        begin
            p.pos_x = solve_axis(c * e - f * bb, det, clip);
            p.pos_y = solve_axis(a * f - c * d, det, clip);
            p.clipped = clip;
        end
        return p;
    endfunction

    // the driver sends one beat per handshake, random gap after each unless quiet
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                position_q.push_back(predict_position(in_data));
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (range_q.size() != 0)
                begin
                    in_data  <= range_q.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= quiet ? 0 : $urandom_range(0, 11);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // the monitor checks each beat, then stalls at random unless quiet, plus one long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            recv_stall <= 0;
            hold_left  <= 0;
        end
        else
        begin
            cycles <= cycles + 1;
            if (cycles >= CycleLimit)
            begin
                $display("TB_ERROR");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                if (position_q.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors = errors + 1;
                end
                else
                begin
                    out_beat_t want;
                    want = position_q.pop_front();
                    if (out_data.pos_x !== want.pos_x)
                    begin
                        $error("pos_x exp %0d got %0d", want.pos_x, out_data.pos_x);
                        errors = errors + 1;
                    end
                    if (out_data.pos_y !== want.pos_y)
                    begin
                        $error("pos_y exp %0d got %0d", want.pos_y, out_data.pos_y);
                        errors = errors + 1;
                    end
                    if (out_data.degenerate !== want.degenerate)
                    begin
                        $error("degenerate exp %0d got %0d", want.degenerate,
                               out_data.degenerate);
                        errors = errors + 1;
                    end
                    if (out_data.clipped !== want.clipped)
                    begin
                        $error("clipped exp %0d got %0d", want.clipped, out_data.clipped);
                        errors = errors + 1;
                    end
                end
            end
            if (long_hold_req && !long_hold_done)
            begin
                long_hold_done <= 1'b1;
                hold_left      <= 400;
                out_ready      <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (out_valid && out_ready)
            begin
                int s;
                s = quiet ? 0 : $urandom_range(0, 11);
                recv_stall <= s;
                out_ready  <= (s == 0);
            end
            else if (recv_stall != 0)
            begin
                recv_stall <= recv_stall - 1;
                out_ready  <= (recv_stall == 1);
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [CoordWidth-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx < RegCount)
            anchor_xy[idx] = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_anchors(input int ax, input int ay, input int bx, input int by,
                               input int cx, input int cy);
        write_reg(REG_ONE_X, ax[CoordWidth-1:0]);
        write_reg(REG_ONE_Y, ay[CoordWidth-1:0]);
        write_reg(REG_TWO_X, bx[CoordWidth-1:0]);
        write_reg(REG_TWO_Y, by[CoordWidth-1:0]);
        write_reg(REG_THREE_X, cx[CoordWidth-1:0]);
        write_reg(REG_THREE_Y, cy[CoordWidth-1:0]);
    endtask

    task automatic push_ranges(input int r1, input int r2, input int r3);
        in_beat_t b;
        b.range_one   = r1[RangeWidth-1:0];
        b.range_two   = r2[RangeWidth-1:0];
        b.range_three = r3[RangeWidth-1:0];
        range_q.push_back(b);
    endtask

    function automatic int range_to(int px, int py, int ax, int ay);
        real span;
        int  r;
        span = $sqrt(real'(px - ax) * real'(px - ax) + real'(py - ay) * real'(py - ay));
        r = $rtoi(span) + $urandom_range(0, 2) - 1;
        if (r < 0)
            r = 0;
        if (r > 65535)
            r = 65535;
        return r;
    endfunction

    task automatic push_random(input int n);
        int px, py, kind;
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 6)
            begin
                px = $urandom_range(0, 20000) - 10000;
                py = $urandom_range(0, 20000) - 10000;
                push_ranges(range_to(px, py, anchor_xy[0], anchor_xy[1]),
                            range_to(px, py, anchor_xy[2], anchor_xy[3]),
                            range_to(px, py, anchor_xy[4], anchor_xy[5]));
            end
            else if (kind < 8)
                push_ranges($urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 65535));
            else
                push_ranges($urandom_range(0, 300), $urandom_range(0, 300),
                            $urandom_range(0, 300));
        end
    endtask

    // hold until every beat is sent and every result checked
    task automatic drain();
        while (range_q.size() != 0 || in_valid || position_q.size() != 0)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);
    endtask

    task automatic corner_ranges();
        push_ranges(0, 0, 0);
        push_ranges(65535, 65535, 65535);
        push_ranges(65535, 0, 0);
        push_ranges(0, 65535, 0);
        push_ranges(0, 0, 65535);
        push_ranges(21845, 43690, 65535);
    endtask

    initial
    begin
        for (int i = 0; i < RegCount; i++)
            anchor_xy[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        corner_ranges();
        drain();

        set_anchors(0, 0, 100, 0, 0, 100);
        push_ranges(50, 50, 50);
        push_ranges(0, 100, 100);
        quiet = 1'b1;
        push_random(40);
        long_hold_req = 1'b1;
        push_random(80);
        drain();
        quiet = 1'b0;
        push_random(60);
        drain();

        set_anchors(-32768, -32768, 32767, -32768, -32768, 32767);
        write_reg(REG_SPARE_SIX, 16'h1234);
        write_reg(REG_SPARE_SEVEN, 16'hffff);
        corner_ranges();
        push_random(50);
        drain();

        set_anchors(0, 0, 10, 10, 20, 20);
        push_ranges(3, 7, 11);
        push_random(15);
        drain();

        set_anchors(0, 0, 1, 0, 0, 1);
        corner_ranges();
        push_random(25);
        drain();

        set_anchors(32767, 32767, -32768, 32767, 32767, -32768);
        push_random(30);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            quiet = ($urandom_range(0, 2) == 0);
            set_anchors($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 65535));
            push_random(30);
            drain();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/bt2d_pkg.sv
rtl/bt2d_div_cell.sv
rtl/bt2d_front.sv
rtl/beacon_trilateration_2d_top.sv
rtl/bt2d_checker.sv
dv/testbench.sv
